### rtl/core/lca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_pkg
// shared constants, payload types and helpers of the lowest common ancestor
// engine (euler tour plus sparse table)
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int MAX_V     = 1024;
    localparam int VW        = 10;            // vertex id width
    localparam int NW        = 11;            // vertex count width
    localparam int PW        = 11;            // tour position width
    localparam int EW        = 12;            // edge index width, holds nil
    localparam int DW        = 10;            // depth width
    localparam int SPW       = 11;            // stack pointer width
    localparam int EDGE_CAP  = 2 * MAX_V;
    localparam int TSLOTS    = 2 * MAX_V;
    localparam int TOUR_CAP  = TSLOTS - 1;
    localparam int LEVELS    = 11;
    localparam int LW        = 4;             // level index width
    localparam int TT_DEPTH  = LEVELS * TSLOTS;
    localparam int TT_AW     = LW + PW;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 11;

    localparam logic [EW-1:0] EDGE_NIL = EW'(EDGE_CAP);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        REG_VCOUNT = 2'd0,
        REG_ROOT   = 2'd1
    } t_reg;

    typedef struct packed {
        logic [NW-1:0] n;        // vertex count after clamping
        logic [VW-1:0] root;
        logic          wr;       // a register was written
    } t_cfg;

    typedef struct packed {
        logic          reached;
        logic [PW-1:0] first;
        logic [DW-1:0] depth;
    } t_vinfo;

    typedef struct packed {
        logic [VW-1:0] v;
        logic [EW-1:0] next;
    } t_frame;

    typedef struct packed {
        logic [VW-1:0] target;
        logic [EW-1:0] link;
    } t_edge;

    typedef struct packed {
        logic [VW-1:0] v;
        logic [DW-1:0] depth;
    } t_tent;

    // on equal depth the second entry wins
    function automatic t_tent shallower(t_tent x, t_tent y);
        return (x.depth < y.depth) ? x : y;
    endfunction

    function automatic logic [TT_AW-1:0] tt_addr(logic [LW-1:0] lvl, logic [PW-1:0] pos);
        return {lvl, pos};
    endfunction

endpackage
`default_nettype wire

### rtl/core/lca_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca channel interfaces
// command, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface lca_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [lca_pkg::VW-1:0]   vertex_a;
    logic [lca_pkg::VW-1:0]   vertex_b;
    modport source (output valid, cmd, vertex_a, vertex_b, input ready);
    modport sink   (input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

interface lca_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [lca_pkg::VW-1:0]   ancestor;
    logic                     valid_res;
    modport source (output valid, ancestor, valid_res, input ready);
    modport sink   (input valid, ancestor, valid_res, output ready);
endinterface

interface lca_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lca_pkg::CFG_IW-1:0]   index;
    logic [lca_pkg::CFG_DW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/tree_lca_euler_sparse_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tree_lca_euler_sparse_table_top
// lowest common ancestor engine: edge lists, euler tour walk, sparse table
// add edge: states S_E2 and S_E3; query: S_Q2 (when built and in range) and
//   S_Q3, result registered in S_Q3 once the output is free and held until taken
// build: vertex clear over all MAX_V entries, root setup, the walk steps,
//   a depth pass over the tour entries, then the sparse table fill per level
// all work is serialized by the single memory sequencer, one command at a time
// reset: edge-list clearing pass, no commands taken meanwhile
// ----------------------------------------------------------------------------
module tree_lca_euler_sparse_table_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lca_req_if.sink     i_req,
    lca_rsp_if.source   o_rsp,
    lca_cfg_if.sink     i_cfg
);
    import lca_pkg::*;

    logic [NW-1:0] r_vcount;
    logic [VW-1:0] r_root;
    t_cfg          cfg;
    logic          cfg_known;

    assign i_cfg.ready = 1'b1;
    assign cfg_known   = (i_cfg.index == REG_VCOUNT) || (i_cfg.index == REG_ROOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= NW'(MAX_V);
            r_root   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_VCOUNT: r_vcount <= i_cfg.data;
                REG_ROOT:   r_root   <= i_cfg.data[VW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.root = r_root;
        cfg.wr   = i_cfg.valid && cfg_known;
        if (r_vcount == '0)               cfg.n = NW'(1);
        else if (r_vcount > NW'(MAX_V))   cfg.n = NW'(MAX_V);
        else                              cfg.n = r_vcount;
    end

    lca_ctrl u_ctrl (
        .i_clk,
        .i_rst_n,
        .i_cfg (cfg),
        .i_req (i_req),
        .o_rsp (o_rsp)
    );

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req.ready)
        else $error("command taken during edge-list clearing");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.cmd == CMD_QUERY)) |=> !i_req.ready)
        else $error("query transaction did not occupy the sequencer");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.valid_res) |-> (o_rsp.ancestor == '0))
        else $error("invalid answer carries a nonzero ancestor");
endmodule
`default_nettype wire

### rtl/core/lca_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_ram
// single write, dual read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_wa,
    input  wire logic [WIDTH-1:0]          i_wd,
    input  wire logic                      i_re0,
    input  wire logic [$clog2(DEPTH)-1:0]  i_ra0,
    output      logic [WIDTH-1:0]          o_rd0,
    input  wire logic                      i_re1,
    input  wire logic [$clog2(DEPTH)-1:0]  i_ra1,
    output      logic [WIDTH-1:0]          o_rd1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re0) begin
            o_rd0 <= r_mem[i_ra0];
        end
        if (i_re1) begin
            o_rd1 <= r_mem[i_ra1];
        end
    end
endmodule
`default_nettype wire

### rtl/core/lca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_ctrl
// command sequencer: edge list insert, depth-first walk, sparse table fill
// and ancestor query over the edge, stack, vertex and tour memories
// ----------------------------------------------------------------------------
module lca_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lca_pkg::t_cfg   i_cfg,
    lca_req_if.sink              i_req,
    lca_rsp_if.source            o_rsp
);
    import lca_pkg::*;

    typedef enum logic [19:0] {
        S_CLR   = 20'h00001,
        S_IDLE  = 20'h00002,
        S_E2    = 20'h00004,
        S_E3    = 20'h00008,
        S_BCLR  = 20'h00010,
        S_ROOT  = 20'h00020,
        S_ROOT2 = 20'h00040,
        S_WALK  = 20'h00080,
        S_EDGE  = 20'h00100,
        S_ENTER = 20'h00200,
        S_POP   = 20'h00400,
        S_A1    = 20'h00800,
        S_A2    = 20'h01000,
        S_A3    = 20'h02000,
        S_F1    = 20'h04000,
        S_F2    = 20'h08000,
        S_Q2    = 20'h10000,
        S_Q3    = 20'h20000,
        S_SPARE = 20'h40000,
        S_SPARE2 = 20'h80000
    } t_state;

    t_state           r_state, n_state;
    logic [VW-1:0]    r_a, r_b, r_top_v, r_par_v, r_w;
    logic [EW-1:0]    r_ecount, r_top_e;
    logic [PW-1:0]    r_len, r_j;
    logic [SPW-1:0]   r_sp;
    logic [LW-1:0]    r_i;
    logic             r_built, r_qok;
    logic             r_out_valid, r_out_ok;
    logic [VW-1:0]    r_out_anc;

    // memory ports
    logic             hd_we, hd_re0, hd_re1;
    logic [VW-1:0]    hd_wa, hd_ra0, hd_ra1;
    logic [EW-1:0]    hd_wd, hd_rd0, hd_rd1;
    logic             eg_we, eg_re0;
    logic [PW-1:0]    eg_wa, eg_ra0;
    t_edge            eg_wd, eg_rd0;
    logic             st_we, st_re0, st_re1;
    logic [VW-1:0]    st_wa, st_ra0, st_ra1;
    t_frame           st_wd, st_rd0, st_rd1;
    logic             vi_we, vi_re0, vi_re1;
    logic [VW-1:0]    vi_wa, vi_ra0, vi_ra1;
    t_vinfo           vi_wd, vi_rd0, vi_rd1;
    logic             tt_we, tt_re0, tt_re1;
    logic [TT_AW-1:0] tt_wa, tt_ra0, tt_ra1;
    t_tent            tt_wd, tt_rd0, tt_rd1;

    logic             accept, a_in, b_in, add_ok, q_pre;
    logic             pop_last, pop_fail, edge_skip, edge_fail;
    logic             a3_last, f_last;
    logic [PW:0]      f_sum;
    logic [PW-1:0]    f_k, len_m1;
    logic [PW-1:0]    q_l, q_r, q_width, q_hi;
    logic [LW-1:0]    q_k;
    logic             q_ok, out_free;

    lca_ram #(.DEPTH(MAX_V), .WIDTH(EW)) u_head (
        .i_clk, .i_we(hd_we), .i_wa(hd_wa), .i_wd(hd_wd),
        .i_re0(hd_re0), .i_ra0(hd_ra0), .o_rd0(hd_rd0),
        .i_re1(hd_re1), .i_ra1(hd_ra1), .o_rd1(hd_rd1)
    );
    lca_ram #(.DEPTH(EDGE_CAP), .WIDTH($bits(t_edge))) u_edge (
        .i_clk, .i_we(eg_we), .i_wa(eg_wa), .i_wd(eg_wd),
        .i_re0(eg_re0), .i_ra0(eg_ra0), .o_rd0(eg_rd0),
        .i_re1(1'b0), .i_ra1('0), .o_rd1()
    );
    lca_ram #(.DEPTH(MAX_V), .WIDTH($bits(t_frame))) u_stack (
        .i_clk, .i_we(st_we), .i_wa(st_wa), .i_wd(st_wd),
        .i_re0(st_re0), .i_ra0(st_ra0), .o_rd0(st_rd0),
        .i_re1(st_re1), .i_ra1(st_ra1), .o_rd1(st_rd1)
    );
    lca_ram #(.DEPTH(MAX_V), .WIDTH($bits(t_vinfo))) u_vinfo (
        .i_clk, .i_we(vi_we), .i_wa(vi_wa), .i_wd(vi_wd),
        .i_re0(vi_re0), .i_ra0(vi_ra0), .o_rd0(vi_rd0),
        .i_re1(vi_re1), .i_ra1(vi_ra1), .o_rd1(vi_rd1)
    );
    lca_ram #(.DEPTH(TT_DEPTH), .WIDTH($bits(t_tent))) u_tour (
        .i_clk, .i_we(tt_we), .i_wa(tt_wa), .i_wd(tt_wd),
        .i_re0(tt_re0), .i_ra0(tt_ra0), .o_rd0(tt_rd0),
        .i_re1(tt_re1), .i_ra1(tt_ra1), .o_rd1(tt_rd1)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign accept          = i_req.valid && i_req.ready;
    assign a_in            = {1'b0, i_req.vertex_a} < i_cfg.n;
    assign b_in            = {1'b0, i_req.vertex_b} < i_cfg.n;
    assign add_ok          = a_in && b_in && (r_ecount <= EW'(EDGE_CAP - 2));
    assign q_pre           = r_built && a_in && b_in;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.ancestor  = r_out_anc;
    assign o_rsp.valid_res = r_out_ok;
    assign out_free        = !r_out_valid || o_rsp.ready;

    assign len_m1    = r_len - PW'(1);
    assign pop_last  = (r_sp == SPW'(1));
    assign pop_fail  = (r_len >= PW'(TOUR_CAP));
    // skip the edge back to the parent and edges to unused vertices
    assign edge_skip = ((r_sp >= SPW'(2)) && (eg_rd0.target == r_par_v))
                    || ({1'b0, eg_rd0.target} >= i_cfg.n);
    assign edge_fail = (r_sp >= SPW'(MAX_V)) || (r_len >= PW'(TOUR_CAP));
    assign a3_last   = (r_j == len_m1);
    assign f_last    = (r_j == len_m1);
    assign f_sum     = {1'b0, r_j} + ((PW+1)'(1) << r_i);
    assign f_k       = (f_sum > {1'b0, len_m1}) ? len_m1 : f_sum[PW-1:0];

    // query range and level
    always_comb begin
        q_l     = (vi_rd0.first > vi_rd1.first) ? vi_rd1.first : vi_rd0.first;
        q_r     = (vi_rd0.first > vi_rd1.first) ? vi_rd0.first : vi_rd1.first;
        q_width = q_r - q_l + PW'(1);
        q_k     = '0;
        for (int t = 0; t < PW; t++) begin
            if (q_width[t]) begin
                q_k = LW'(t);
            end
        end
        q_hi = q_r - (PW'(1) << q_k) + PW'(1);
        q_ok = vi_rd0.reached && vi_rd1.reached && (q_k < LW'(LEVELS));
    end

    // memory port control
    always_comb begin
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0;
        hd_re0 = 1'b0; hd_ra0 = '0; hd_re1 = 1'b0; hd_ra1 = '0;
        eg_we = 1'b0; eg_wa = '0; eg_wd = '0; eg_re0 = 1'b0; eg_ra0 = '0;
        st_we = 1'b0; st_wa = '0; st_wd = '0;
        st_re0 = 1'b0; st_ra0 = '0; st_re1 = 1'b0; st_ra1 = '0;
        vi_we = 1'b0; vi_wa = '0; vi_wd = '0;
        vi_re0 = 1'b0; vi_ra0 = '0; vi_re1 = 1'b0; vi_ra1 = '0;
        tt_we = 1'b0; tt_wa = '0; tt_wd = '0;
        tt_re0 = 1'b0; tt_ra0 = '0; tt_re1 = 1'b0; tt_ra1 = '0;
        unique case (r_state)
            S_CLR: begin
                hd_we = 1'b1;
                hd_wa = r_j[VW-1:0];
                hd_wd = EDGE_NIL;
            end
            S_IDLE: begin
                if (accept && (i_req.cmd == CMD_ADD)) begin
                    hd_re0 = 1'b1; hd_ra0 = i_req.vertex_a;
                    hd_re1 = 1'b1; hd_ra1 = i_req.vertex_b;
                end
                if (accept && (i_req.cmd == CMD_QUERY)) begin
                    vi_re0 = 1'b1; vi_ra0 = i_req.vertex_a;
                    vi_re1 = 1'b1; vi_ra1 = i_req.vertex_b;
                end
            end
            S_E2: begin
                eg_we = 1'b1;
                eg_wa = r_ecount[PW-1:0];
                eg_wd = '{target: r_b, link: hd_rd0};
                hd_we = 1'b1;
                hd_wa = r_a;
                hd_wd = r_ecount;
            end
            S_E3: begin
                eg_we = 1'b1;
                eg_wa = r_ecount[PW-1:0] + PW'(1);
                // a self loop links to the entry written in S_E2
                eg_wd = '{target: r_a, link: (r_a == r_b) ? r_ecount : hd_rd1};
                hd_we = 1'b1;
                hd_wa = r_b;
                hd_wd = r_ecount + EW'(1);
            end
            S_BCLR: begin
                vi_we = 1'b1;
                vi_wa = r_j[VW-1:0];
                vi_wd = '0;
            end
            S_ROOT: begin
                hd_re0 = 1'b1;
                hd_ra0 = i_cfg.root;
            end
            S_ROOT2: begin
                vi_we = 1'b1; vi_wa = i_cfg.root;
                vi_wd = '{reached: 1'b1, first: '0, depth: '0};
                tt_we = 1'b1; tt_wa = tt_addr('0, '0);
                tt_wd = '{v: i_cfg.root, depth: '0};
                st_we = 1'b1; st_wa = '0;
                st_wd = '{v: i_cfg.root, next: hd_rd0};
            end
            S_WALK: begin
                if (r_top_e < r_ecount) begin
                    eg_re0 = 1'b1;
                    eg_ra0 = r_top_e[PW-1:0];
                end else if (!pop_last && !pop_fail) begin
                    st_re0 = 1'b1; st_ra0 = VW'(r_sp - SPW'(2));
                    st_re1 = 1'b1; st_ra1 = VW'(r_sp - SPW'(3));
                end
            end
            S_EDGE: begin
                // write back the advanced edge cursor of the top frame
                st_we = 1'b1;
                st_wa = VW'(r_sp - SPW'(1));
                st_wd = '{v: r_top_v, next: eg_rd0.link};
                if (!edge_skip && !edge_fail) begin
                    vi_re0 = 1'b1; vi_ra0 = r_top_v;
                    hd_re0 = 1'b1; hd_ra0 = eg_rd0.target;
                end
            end
            S_ENTER: begin
                vi_we = 1'b1; vi_wa = r_w;
                vi_wd = '{reached: 1'b1, first: r_len, depth: vi_rd0.depth + DW'(1)};
                tt_we = 1'b1; tt_wa = tt_addr('0, r_len);
                tt_wd = '{v: r_w, depth: '0};
                st_we = 1'b1; st_wa = r_sp[VW-1:0];
                st_wd = '{v: r_w, next: hd_rd0};
            end
            S_POP: begin
                tt_we = 1'b1; tt_wa = tt_addr('0, r_len);
                tt_wd = '{v: st_rd0.v, depth: '0};
            end
            S_A1: begin
                tt_re0 = 1'b1; tt_ra0 = tt_addr('0, r_j);
            end
            S_A2: begin
                vi_re0 = 1'b1; vi_ra0 = tt_rd0.v;
            end
            S_A3: begin
                // tour entries take the final depth of their vertex
                tt_we = 1'b1; tt_wa = tt_addr('0, r_j);
                tt_wd = '{v: r_w, depth: vi_rd0.depth};
            end
            S_F1: begin
                tt_re0 = 1'b1; tt_ra0 = tt_addr(r_i, r_j);
                tt_re1 = 1'b1; tt_ra1 = tt_addr(r_i, f_k);
            end
            S_F2: begin
                tt_we = 1'b1; tt_wa = tt_addr(r_i + LW'(1), r_j);
                tt_wd = shallower(tt_rd0, tt_rd1);
            end
            S_Q2: begin
                if (q_ok) begin
                    tt_re0 = 1'b1; tt_ra0 = tt_addr(q_k, q_l);
                    tt_re1 = 1'b1; tt_ra1 = tt_addr(q_k, q_hi);
                end
            end
            S_Q3, S_SPARE, S_SPARE2: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_j == PW'(MAX_V - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (i_req.cmd)
                        CMD_ADD:   n_state = add_ok ? S_E2 : S_IDLE;
                        CMD_BUILD: n_state = ({1'b0, i_cfg.root} < i_cfg.n) ? S_BCLR : S_IDLE;
                        CMD_QUERY: n_state = q_pre ? S_Q2 : S_Q3;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_E2:    n_state = S_E3;
            S_E3:    n_state = S_IDLE;
            S_BCLR:  if (r_j == PW'(MAX_V - 1)) n_state = S_ROOT;
            S_ROOT:  n_state = S_ROOT2;
            S_ROOT2: n_state = S_WALK;
            S_WALK: begin
                if (r_top_e < r_ecount) n_state = S_EDGE;
                else if (pop_last)      n_state = S_A1;
                else if (pop_fail)      n_state = S_IDLE;
                else                    n_state = S_POP;
            end
            S_EDGE: begin
                if (edge_skip)      n_state = S_WALK;
                else if (edge_fail) n_state = S_IDLE;
                else                n_state = S_ENTER;
            end
            S_ENTER: n_state = S_WALK;
            S_POP:   n_state = S_WALK;
            S_A1:    n_state = S_A2;
            S_A2:    n_state = S_A3;
            S_A3:    n_state = a3_last ? S_F1 : S_A1;
            S_F1:    n_state = S_F2;
            S_F2:    n_state = (f_last && (r_i == LW'(LEVELS - 2))) ? S_IDLE : S_F1;
            S_Q2:    n_state = S_Q3;
            S_Q3:    if (out_free) n_state = S_IDLE;
            S_SPARE, S_SPARE2: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_j         <= '0;
            r_built     <= 1'b0;
            r_ecount    <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new answer loaded in S_Q3 replaces the one just taken
            if (o_rsp.valid && o_rsp.ready && (r_state != S_Q3)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.wr || (accept && (i_req.cmd inside {CMD_ADD, CMD_BUILD}))) begin
                r_built <= 1'b0;
            end else if ((r_state == S_F2) && f_last && (r_i == LW'(LEVELS - 2))) begin
                r_built <= 1'b1;
            end
            unique case (r_state)
                S_CLR: r_j <= r_j + PW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_a <= i_req.vertex_a;
                        r_b <= i_req.vertex_b;
                        case (i_req.cmd)
                            CMD_BUILD: begin
                                r_len   <= '0;
                                r_j     <= '0;
                            end
                            CMD_QUERY: r_qok <= q_pre;
                            default: begin
                            end
                        endcase
                    end
                end
                S_E3:   r_ecount <= r_ecount + EW'(2);
                S_BCLR: r_j <= r_j + PW'(1);
                S_ROOT2: begin
                    r_sp    <= SPW'(1);
                    r_top_v <= i_cfg.root;
                    r_top_e <= hd_rd0;
                    r_len   <= PW'(1);
                end
                S_WALK: begin
                    if (r_top_e >= r_ecount) begin
                        if (pop_last) begin
                            r_sp <= '0;
                            r_j  <= '0;
                        end else if (!pop_fail) begin
                            r_sp <= r_sp - SPW'(1);
                        end
                    end
                end
                S_EDGE: begin
                    r_top_e <= eg_rd0.link;
                    r_w     <= eg_rd0.target;
                end
                S_ENTER: begin
                    r_par_v <= r_top_v;
                    r_top_v <= r_w;
                    r_top_e <= hd_rd0;
                    r_sp    <= r_sp + SPW'(1);
                    r_len   <= r_len + PW'(1);
                end
                S_POP: begin
                    r_top_v <= st_rd0.v;
                    r_top_e <= st_rd0.next;
                    r_par_v <= st_rd1.v;
                    r_len   <= r_len + PW'(1);
                end
                S_A2: r_w <= tt_rd0.v;
                S_A3: begin
                    r_j <= a3_last ? '0 : r_j + PW'(1);
                    if (a3_last) begin
                        r_i <= '0;
                    end
                end
                S_F2: begin
                    if (f_last) begin
                        r_j <= '0;
                        if (r_i != LW'(LEVELS - 2)) begin
                            r_i <= r_i + LW'(1);
                        end
                    end else begin
                        r_j <= r_j + PW'(1);
                    end
                end
                S_Q2: r_qok <= q_ok;
                S_Q3: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_qok;
                        r_out_anc   <= r_qok ? shallower(tt_rd0, tt_rd1).v : '0;
                    end
                end
                S_ROOT, S_A1, S_F1, S_SPARE, S_SPARE2: begin
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### bench/tb_tree_lca_euler_sparse_table_top.sv
// ----------------------------------------------------------------------------
// tb_tree_lca_euler_sparse_table_top
// Self-checking bench for the lowest common ancestor engine. Each phase puts
// a small random tree on a fresh block of vertex ids, builds the tables and
// asks random ancestor queries. Some phases also carry noise edges, cycles
// and out-of-range vertices, and the run ends with a burst of random edges
// over the whole vertex range. A scoreboard keeps its own model of the
// engine and checks every response.
// ----------------------------------------------------------------------------
module tb_tree_lca_euler_sparse_table_top;
    import lca_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [VW-1:0] ancestor;
        logic          valid_res;
    } t_answer;

    class lca_scoreboard;
        int      head[MAX_V];
        int      etgt[EDGE_CAP];
        int      elnk[EDGE_CAP];
        int      ecnt;
        int      dep[MAX_V];
        int      fpos[MAX_V];
        bit      seen[MAX_V];
        int      tour[LEVELS][TSLOTS];
        int      tlen;
        int      wv[MAX_V];
        int      wn[MAX_V];
        bit      built;
        int      vcnt;
        int      root;
        int      settle_cycles;
        int      errors;
        t_answer answers[$];

        function new();
            foreach (head[v]) head[v] = EDGE_CAP;
            foreach (seen[v]) seen[v] = 0;
            ecnt = 0;
            tlen = 0;
            built = 0;
            vcnt = MAX_V;
            root = 0;
            settle_cycles = 10;
            errors = 0;
        endfunction

        function int used_n();
            if (vcnt < 1) return 1;
            if (vcnt > MAX_V) return MAX_V;
            return vcnt;
        endfunction

        function int upper(int x, int y);
            return (dep[x] < dep[y]) ? x : y;
        endfunction

        function void write_reg(t_reg idx, int val);
            if (idx == REG_VCOUNT) vcnt = val & 'h7FF;
            else root = val & 'h3FF;
            built = 0;
        endfunction

        function void enter(int v);
            fpos[v] = tlen;
            seen[v] = 1;
            tour[0][tlen] = v;
            tlen++;
        endfunction

        function void add_edge(int a, int b);
            int n;
            n = used_n();
            built = 0;
            if (a >= n || b >= n || ecnt + 2 > EDGE_CAP) return;
            etgt[ecnt] = b;
            elnk[ecnt] = head[a];
            head[a] = ecnt;
            ecnt++;
            etgt[ecnt] = a;
            elnk[ecnt] = head[b];
            head[b] = ecnt;
            ecnt++;
        endfunction

        function void walk_tree();
            int n, sp, top, e, w;
            n = used_n();
            built = 0;
            tlen = 0;
            foreach (seen[v]) seen[v] = 0;
            if (root >= n) return;
            dep[root] = 0;
            enter(root);
            wv[0] = root;
            wn[0] = head[root];
            sp = 1;
            while (sp > 0) begin
                top = sp - 1;
                e = wn[top];
                if (e >= ecnt) begin
                    sp--;
                    if (sp > 0) begin
                        if (tlen >= TOUR_CAP) return;
                        tour[0][tlen] = wv[sp-1];
                        tlen++;
                    end
                    continue;
                end
                wn[top] = elnk[e];
                w = etgt[e];
                if (top >= 1 && w == wv[top-1]) continue;
                if (w >= n) continue;
                if (sp >= MAX_V || tlen >= TOUR_CAP) return;
                dep[w] = dep[wv[top]] + 1;
                enter(w);
                wv[sp] = w;
                wn[sp] = head[w];
                sp++;
            end
            for (int i = 0; i + 1 < LEVELS; i++) begin
                for (int j = 0; j < tlen; j++) begin
                    int k;
                    k = j + (1 << i);
                    if (k > tlen - 1) k = tlen - 1;
                    tour[i+1][j] = upper(tour[i][j], tour[i][k]);
                end
            end
            built = 1;
        endfunction

        function t_answer ancestor_of(int a, int b);
            t_answer res;
            int n, l, r, width, k;
            n = used_n();
            res.ancestor = '0;
            res.valid_res = 1'b0;
            if (!built || a >= n || b >= n || !seen[a] || !seen[b]) return res;
            l = fpos[a];
            r = fpos[b];
            if (l > r) begin
                k = l;
                l = r;
                r = k;
            end
            width = r - l + 1;
            k = 0;
            while ((width >> (k + 1)) != 0) k++;
            if (k >= LEVELS) return res;
            res.ancestor = VW'(upper(tour[k][l], tour[k][r - (1 << k) + 1]));
            res.valid_res = 1'b1;
            return res;
        endfunction

        // note one accepted command transaction
        function void note_command(logic [1:0] cmd, int a, int b);
            case (cmd)
                CMD_ADD: begin
                    add_edge(a, b);
                    settle_cycles = 10;
                end
                CMD_BUILD: begin
                    walk_tree();
                    settle_cycles = 1200 + 30 * tlen + 4 * ecnt;
                end
                CMD_QUERY: begin
                    answers.insert(answers.size(), ancestor_of(a, b));
                    settle_cycles = 10;
                end
                default: ;
            endcase
        endfunction

        function void check_answer(logic [VW-1:0] anc, logic ok);
            t_answer exp_a;
            if (answers.size() == 0) begin
                $error("response with no query waiting: ancestor %0d valid_res %0d", anc, ok);
                errors++;
                return;
            end
            exp_a = answers.pop_front();
            if (ok !== exp_a.valid_res) begin
                $error("valid_res expected %0d actual %0d", exp_a.valid_res, ok);
                errors++;
            end
            if (anc !== exp_a.ancestor) begin
                $error("ancestor expected %0d actual %0d", exp_a.ancestor, anc);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lca_req_if req_ch();
    lca_rsp_if rsp_ch();
    lca_cfg_if cfg_ch();

    tree_lca_euler_sparse_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    lca_scoreboard sb;
    bit calm;
    int hold_cycles;
    int sent;
    int next_free;
    int edge_a[$];
    int edge_b[$];

    initial i_clk = 1'b0;

    always #2 i_clk = ~i_clk;

    initial begin
        #8000000;
        $display("tb_tree_lca_euler_sparse_table_top failed");
        $finish;
    end

    // response side: random back-pressure plus one long hold-off in phase 4
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            hold_cycles--;
        end else begin
            rsp_ch.ready = calm || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_answer(rsp_ch.ancestor, rsp_ch.valid_res);
    end

    task automatic send(logic [1:0] cmd, int a, int b);
        if (!calm) begin
            while ($urandom_range(99) < 31) begin
                req_ch.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_ch.valid = 1'b1;
        req_ch.cmd = cmd;
        req_ch.vertex_a = VW'(a);
        req_ch.vertex_b = VW'(b);
        do @(posedge i_clk); while (!req_ch.ready);
        // the block sees only the low vertex bits
        sb.note_command(cmd, a & 'h3FF, b & 'h3FF);
        sent++;
        @(negedge i_clk);
    endtask

    // wait for every response, then for the block to go quiet
    task automatic drain();
        req_ch.valid = 1'b0;
        while (sb.answers.size() != 0) @(negedge i_clk);
        repeat (sb.settle_cycles) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, int val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = CFG_DW'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic int pick_vertex(int base, int k);
        int r;
        r = $urandom_range(99);
        if (r < 85) return base + $urandom_range(k - 1);
        if (r < 93) return $urandom_range(1023);
        return sb.used_n() - 1 + $urandom_range(1);
    endfunction

    task automatic tree_phase(int phase);
        int base, k, vc, r, nq;
        k = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(3, 40);
        if (next_free + k > 1000) k = 1000 - next_free;
        base = next_free;
        next_free += k;
        r = $urandom_range(3);
        if (r == 0) vc = 1024;
        else if (r == 1) vc = base + k - 1;
        else vc = base + k + $urandom_range(30);
        if (vc > 1024) vc = 1024;
        write_reg(REG_VCOUNT, vc);
        write_reg(REG_ROOT, base);
        calm = (phase == 3);

        edge_a.delete();
        edge_b.delete();
        for (int i = 1; i < k; i++) begin
            int p;
            p = (phase % 7 == 5) ? i - 1 : $urandom_range(i - 1);
            if ($urandom_range(1)) begin
                edge_a.insert(edge_a.size(), base + i);
                edge_b.insert(edge_b.size(), base + p);
            end else begin
                edge_a.insert(edge_a.size(), base + p);
                edge_b.insert(edge_b.size(), base + i);
            end
        end
        // shuffle the edge order
        for (int i = edge_a.size() - 1; i > 0; i--) begin
            int j, t;
            j = $urandom_range(i);
            t = edge_a[i]; edge_a[i] = edge_a[j]; edge_a[j] = t;
            t = edge_b[i]; edge_b[i] = edge_b[j]; edge_b[j] = t;
        end
        foreach (edge_a[i]) send(CMD_ADD, edge_a[i], edge_b[i]);
        if ($urandom_range(5) == 0) send(CMD_ADD, base, 1023);
        if ($urandom_range(5) == 0) send(CMD_QUERY, base, base + k - 1);
        // a cycle inside the block
        if (phase % 9 == 8 && k > 3) send(CMD_ADD, base + k - 1, base + 1);
        send(CMD_BUILD, 0, 0);
        if ($urandom_range(7) == 0) send(CMD_UNUSED, $urandom_range(1023), $urandom_range(1023));
        if (phase == 4) hold_cycles = 400;
        nq = $urandom_range(4, 20);
        for (int i = 0; i < nq; i++) send(CMD_QUERY, pick_vertex(base, k), pick_vertex(base, k));
        if ($urandom_range(5) == 0) begin
            send(CMD_ADD, base, $urandom_range(1023));
            send(CMD_QUERY, base, base);
            send(CMD_BUILD, 0, 0);
            for (int i = 0; i < 4; i++)
                send(CMD_QUERY, pick_vertex(base, k), pick_vertex(base, k));
        end
        drain();
        calm = 1'b0;
    endtask

    initial begin
        int phase;
        sb = new();
        calm = 1'b0;
        hold_cycles = 0;
        sent = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ADD;
        req_ch.vertex_a = '0;
        req_ch.vertex_b = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_VCOUNT;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: before build, unused command, single vertex, clamping
        send(CMD_QUERY, 0, 0);
        send(CMD_UNUSED, 1023, 1023);
        drain();
        write_reg(REG_VCOUNT, 1);
        write_reg(REG_ROOT, 0);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 0, 0);
        send(CMD_QUERY, 1023, 1023);
        send(CMD_ADD, 0, 1);
        send(CMD_QUERY, 0, 0);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 0, 0);
        drain();
        write_reg(REG_ROOT, 0);
        send(CMD_QUERY, 0, 0);
        drain();
        write_reg(REG_VCOUNT, 5);
        write_reg(REG_ROOT, 1023);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 1023, 1023);
        drain();
        write_reg(REG_VCOUNT, 2047);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 1023, 1023);
        send(CMD_QUERY, 1023, 0);
        drain();
        write_reg(REG_VCOUNT, 0);
        write_reg(REG_ROOT, 0);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 0, 0);
        drain();

        // random trees on fresh vertex blocks
        next_free = 1;
        phase = 0;
        while (sent < 600 && next_free < 960) begin
            tree_phase(phase);
            phase++;
        end

        // random edges over the whole vertex range
        write_reg(REG_VCOUNT, 1024);
        write_reg(REG_ROOT, $urandom_range(1, next_free - 1));
        while (sb.ecnt < EDGE_CAP && sent < 830)
            send(CMD_ADD, $urandom_range(1023), $urandom_range(1023));
        for (int i = 0; i < 3; i++) send(CMD_ADD, $urandom_range(1023), $urandom_range(1023));
        send(CMD_QUERY, 1, 1);
        send(CMD_BUILD, 0, 0);
        for (int i = 0; i < 10; i++) send(CMD_QUERY, $urandom_range(1023), $urandom_range(1023));
        drain();

        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("tb_tree_lca_euler_sparse_table_top passed");
        end else begin
            $display("tb_tree_lca_euler_sparse_table_top failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/lca_pkg.sv
rtl/core/lca_if.sv
rtl/core/lca_ram.sv
rtl/core/lca_ctrl.sv
rtl/core/tree_lca_euler_sparse_table_top.sv
bench/tb_tree_lca_euler_sparse_table_top.sv
